// ----- design/srmp_pkg.sv -----
package srmp_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_MOTION_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MOVE_NEGATIVE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_PULSES = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RAMP_STEPS    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STEP_PULSES   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_BASE_SPEED    = 3'd5;

  // Widest register on the configuration port
  localparam int unsigned CfgDataW = 24;

  // Field widths
  localparam int unsigned EncW    = 32;
  localparam int unsigned TargetW = 24;
  localparam int unsigned StepW   = 4;   // ramp step counters and multiples
  localparam int unsigned PulseW  = 16;
  localparam int unsigned BaseW   = 7;
  localparam int unsigned SpeedW  = 8;

  // Product of a step count and step_pulses
  localparam int unsigned ThrW = StepW + PulseW;
  // Signed deceleration point: target plus or minus a few step spans
  localparam int unsigned DpW  = 27;

  typedef struct packed {
    logic            start_req;
    logic [EncW-1:0] enc_left;
    logic [EncW-1:0] enc_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] speed_cmd;
    logic                     move_done;
  } out_item_t;

endpackage

// ----- design/stepped_ramp_motion_profile_core.sv -----
// Stepped trapezoidal speed ramp for a two-wheel drive.
// Samples pass the input register, the single compute stage and the output register in turn.
// Throughput: one sample per cycle unless stalled; the ramp state updates in that stage.
// The input stage stalls only while the output register holds an untaken result.
// Reset (rst_ni low, asynchronous): no armed move, configuration at its defaults.
module stepped_ramp_motion_profile_core #(
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned MAX_STEPS  = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  srmp_pkg::in_item_t                 in_data_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output srmp_pkg::out_item_t                out_data_o,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [srmp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [srmp_pkg::CfgDataW-1:0]      cfg_data_i
);
  import srmp_pkg::*;

  localparam int unsigned CmpW = ((COUNT_BITS > DpW) ? COUNT_BITS : DpW) + 1;
  localparam logic [StepW-1:0] MaxStepsC = StepW'(MAX_STEPS);

  // Configuration registers
  logic               mode_q, neg_q;
  logic [TargetW-1:0] target_q;
  logic [StepW-1:0]   ramp_q;
  logic [PulseW-1:0]  step_q;
  logic [BaseW-1:0]   base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      neg_q    <= 1'b0;
      target_q <= '0;
      ramp_q   <= '0;
      step_q   <= PulseW'(1);
      base_q   <= BaseW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MOTION_MODE:   mode_q   <= cfg_data_i[0];
        CFG_MOVE_NEGATIVE: neg_q    <= cfg_data_i[0];
        CFG_TARGET_PULSES: target_q <= cfg_data_i[TargetW-1:0];
        CFG_RAMP_STEPS:    ramp_q   <= cfg_data_i[StepW-1:0];
        CFG_STEP_PULSES:   step_q   <= cfg_data_i[PulseW-1:0];
        CFG_BASE_SPEED:    base_q   <= cfg_data_i[BaseW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: input register feeds the compute stage and output register
  logic     s1_valid_q;
  in_item_t s1_data_q;
  logic     out_valid_q;
  out_item_t out_data_q;
  logic     out_ready, s1_adv;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
  end

  // Ramp state
  logic                   moving_q, moving_d;
  logic [StepW-1:0]       steps_q, steps_d;
  logic [StepW-1:0]       accel_q, accel_d;
  logic [StepW-1:0]       decel_q, decel_d;
  logic signed [DpW-1:0]  dp_q, dp_d;
  logic [SpeedW-1:0]      rspeed_q, rspeed_d;
  out_item_t              res_d;

  // base_speed times a multiple, saturated to 8 bits
  function automatic logic [SpeedW-1:0] speed_of(input logic [BaseW-1:0] base,
                                                 input logic [StepW-1:0] mult);
    logic [BaseW+StepW-1:0] prod;
    prod = {{StepW{1'b0}}, base} * {{BaseW{1'b0}}, mult};
    speed_of = (prod > (BaseW+StepW)'(255)) ? 8'hFF : prod[SpeedW-1:0];
  endfunction

  // Signed command from a magnitude, saturated
  function automatic logic [SpeedW-1:0] speed_code(input logic [SpeedW-1:0] mag,
                                                   input logic negative);
    logic [SpeedW-1:0] code;
    if (negative) begin
      code = mag[SpeedW-1] ? 8'h80 : (~mag + 8'd1);
    end else begin
      code = mag[SpeedW-1] ? 8'h7F : mag;
    end
    speed_code = code;
  endfunction

  logic [StepW-1:0]      total, half;
  logic [ThrW-1:0]       half_prod, thr;
  logic                  cmd_neg;
  logic [COUNT_BITS-1:0] raw1, raw2, inv1, inv2, c1, c2;
  logic signed [CmpW-1:0] s1_x, s2_x, thr_x, tgt_x, dp_x;
  logic                  accel_hit, decel_hit, done_hit;

  assign total     = (ramp_q > MaxStepsC) ? MaxStepsC : ramp_q;
  assign half      = total >> 1;
  assign half_prod = {{PulseW{1'b0}}, half} * {{StepW{1'b0}}, step_q};
  assign thr       = {{PulseW{1'b0}}, steps_q + StepW'(1)} * {{StepW{1'b0}}, step_q};
  assign cmd_neg   = mode_q ? !neg_q : neg_q;

  // Count correction per mode and direction: a nonzero count is inverted, zero stays zero
  assign raw1 = s1_data_q.enc_left[COUNT_BITS-1:0];
  assign raw2 = s1_data_q.enc_right[COUNT_BITS-1:0];
  assign inv1 = (raw1 == '0) ? '0 : ~raw1;
  assign inv2 = (raw2 == '0) ? '0 : ~raw2;
  assign c1   = ((neg_q && !mode_q) || (mode_q && !neg_q)) ? inv1 : raw1;
  assign c2   = (neg_q) ? inv2 : raw2;

  // Signed compares at a common width
  assign s1_x  = CmpW'($signed(c1));
  assign s2_x  = CmpW'($signed(c2));
  assign thr_x = $signed(CmpW'(thr));
  assign tgt_x = $signed(CmpW'(target_q));
  assign dp_x  = CmpW'(dp_q);

  assign accel_hit = (steps_q < half) && (s1_x >= thr_x);
  assign decel_hit = (steps_q >= half) && (steps_q < total) && (s1_x >= dp_x);
  assign done_hit  = (s1_x >= tgt_x) && (s2_x >= tgt_x);

  // Next ramp state and result
  always_comb begin
    moving_d  = moving_q;
    steps_d   = steps_q;
    accel_d   = accel_q;
    decel_d   = decel_q;
    dp_d      = dp_q;
    rspeed_d  = rspeed_q;
    res_d.speed_cmd = '0;
    res_d.move_done = 1'b1;
    if (s1_data_q.start_req) begin
      moving_d  = 1'b1;
      steps_d   = '0;
      accel_d   = StepW'(2);
      decel_d   = '0;
      dp_d      = DpW'(target_q) - DpW'(half_prod);
      rspeed_d  = speed_of(base_q, StepW'(1));
      res_d.speed_cmd = speed_code(rspeed_d, cmd_neg);
      res_d.move_done = 1'b0;
    end else if (moving_q) begin
      if (accel_hit) begin
        rspeed_d = speed_of(base_q, accel_q);
        decel_d  = accel_q;
        accel_d  = accel_q + StepW'(2);
        steps_d  = steps_q + StepW'(1);
      end else if (decel_hit) begin
        decel_d  = (decel_q <= StepW'(2)) ? StepW'(1) : (decel_q - StepW'(2));
        rspeed_d = speed_of(base_q, decel_d);
        steps_d  = steps_q + StepW'(1);
        dp_d     = dp_q + DpW'(step_q);
      end
      if (done_hit) begin
        moving_d = 1'b0;
      end else begin
        res_d.speed_cmd = speed_code(rspeed_d, cmd_neg);
        res_d.move_done = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moving_q <= 1'b0;
      steps_q  <= '0;
      accel_q  <= StepW'(2);
      decel_q  <= '0;
      dp_q     <= '0;
      rspeed_q <= '0;
    end else if (s1_adv) begin
      moving_q <= moving_d;
      steps_q  <= steps_d;
      accel_q  <= accel_d;
      decel_q  <= decel_d;
      dp_q     <= dp_d;
      rspeed_q <= rspeed_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- design/srmp_checker.sv -----
module srmp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  srmp_pkg::out_item_t           out_data_o
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // A finished move always commands zero speed
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.move_done |-> out_data_o.speed_cmd == '0)
    else $error("move_done with nonzero speed");

  // Input stalls only while the output register is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // An accepted transaction reaches the output register once it can move
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 (!out_valid_o || !out_stall_i) |=> out_valid_o)
    else $error("accepted transaction did not produce a result");

endmodule

bind stepped_ramp_motion_profile_core srmp_checker u_srmp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- verif/tb_stepped_ramp_motion_profile_core.sv -----
`timescale 1ns / 1ps

module tb_stepped_ramp_motion_profile_core;
  import srmp_pkg::*;

  localparam int unsigned MaxSteps   = 8;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned ItemTarget = 2000;
  // indexes past the last register, expected to be ignored
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = CFG_BASE_SPEED + 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = CFG_BASE_SPEED + 3'd2;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  stepped_ramp_motion_profile_core #(
    .MAX_STEPS (MaxSteps)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Mirror of the configuration registers
  logic                cf_mode;
  logic                cf_negative;
  logic [TargetW-1:0]  cf_target;
  logic [StepW-1:0]    cf_ramp_steps;
  logic [PulseW-1:0]   cf_step_pulses;
  logic [BaseW-1:0]    cf_base;

  // Mirror of the ramp state
  logic                pm_moving;
  logic [StepW-1:0]    pm_steps_done;
  logic [StepW-1:0]    pm_accel_mult;
  logic [StepW-1:0]    pm_decel_mult;
  longint              pm_decel_point;
  logic [SpeedW-1:0]   pm_ramp_speed;

  out_item_t           speed_expect_q[$];
  out_item_t           want_result;
  int unsigned         error_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         ramp_items = 0;
  bit                  quiet = 1'b0;
  int                  stall_left = 0;
  int unsigned         hold_reqs = 0;
  int unsigned         holds_served = 0;

  always #6 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [EncW-1:0] mirror_count(input logic [EncW-1:0] c);
    return (c == '0) ? '0 : ~c;
  endfunction

  function automatic logic [SpeedW-1:0] scaled_speed(input logic [StepW-1:0] mult);
    int unsigned s;
    s = int'(cf_base) * int'(mult);
    return (s > 255) ? 8'd255 : s[SpeedW-1:0];
  endfunction

  // sign follows mode and direction, then clamp to the 8-bit code range
  function automatic logic signed [SpeedW-1:0] signed_cmd(input logic [SpeedW-1:0] mag);
    bit neg;
    int v;
    neg = cf_mode ? !cf_negative : cf_negative;
    v = neg ? -int'(mag) : int'(mag);
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return v[SpeedW-1:0];
  endfunction

  function automatic out_item_t predict_speed_cmd(input in_item_t it);
    logic [EncW-1:0] c1;
    logic [EncW-1:0] c2;
    longint          s1;
    longint          s2;
    longint          tgt;
    int unsigned     total;
    int unsigned     half;
    out_item_t       r;
    tgt   = longint'(cf_target);
    total = (cf_ramp_steps > MaxSteps) ? MaxSteps : cf_ramp_steps;
    half  = total / 2;

    // start: arm the move and command base speed
    if (it.start_req) begin
      pm_moving      = 1'b1;
      pm_steps_done  = '0;
      pm_accel_mult  = 4'd2;
      pm_decel_mult  = '0;
      pm_decel_point = tgt - longint'(half) * longint'(cf_step_pulses);
      pm_ramp_speed  = scaled_speed(4'd1);
      r.speed_cmd    = signed_cmd(pm_ramp_speed);
      r.move_done    = 1'b0;
      return r;
    end
    if (!pm_moving) begin
      r.speed_cmd = '0;
      r.move_done = 1'b1;
      return r;
    end

    // count correction per mode and direction
    c1 = it.enc_left;
    c2 = it.enc_right;
    if (cf_negative && !cf_mode) begin
      c1 = mirror_count(c1);
      c2 = mirror_count(c2);
    end else if (cf_mode && cf_negative) begin
      c2 = mirror_count(c2);
    end else if (cf_mode) begin
      c1 = mirror_count(c1);
    end
    s1 = longint'($signed(c1));
    s2 = longint'($signed(c2));

    // ramp stepping, driven by the first count only
    if (pm_steps_done < half &&
        s1 >= longint'(cf_step_pulses) * (longint'(pm_steps_done) + 1)) begin
      pm_ramp_speed = scaled_speed(pm_accel_mult);
      pm_decel_mult = pm_accel_mult;
      pm_accel_mult = pm_accel_mult + 4'd2;
      pm_steps_done = pm_steps_done + 4'd1;
    end else if (pm_steps_done >= half && pm_steps_done < total &&
                 s1 >= pm_decel_point) begin
      pm_decel_mult  = (pm_decel_mult <= 4'd2) ? 4'd1 : pm_decel_mult - 4'd2;
      pm_ramp_speed  = scaled_speed(pm_decel_mult);
      pm_steps_done  = pm_steps_done + 4'd1;
      pm_decel_point = pm_decel_point + longint'(cf_step_pulses);
    end

    if (s1 >= tgt && s2 >= tgt) begin
      pm_moving   = 1'b0;
      r.speed_cmd = '0;
      r.move_done = 1'b1;
    end else begin
      r.speed_cmd = signed_cmd(pm_ramp_speed);
      r.move_done = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly short bursts, a few long ones
  function automatic int burst_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    return quiet ? 0 : burst_len();
  endfunction

  // raw count that the block corrects back to c
  function automatic logic [EncW-1:0] encode_count(input logic [EncW-1:0] c, input bit inv);
    return inv ? mirror_count(c) : c;
  endfunction

  // random junk above the register's width
  function automatic logic [CfgDataW-1:0] pad_cfg(input logic [CfgDataW-1:0] v,
                                                  input int unsigned w);
    logic [CfgDataW-1:0] noise;
    noise = CfgDataW'($urandom());
    if (w >= CfgDataW) return v;
    return (noise << w) | (v & ((24'd1 << w) - 24'd1));
  endfunction

  // one sample transaction; valid stays high when the next one follows at once
  task automatic send_sample(input in_item_t it);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    speed_expect_q.push_back(predict_speed_cmd(it));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (speed_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MOTION_MODE:   cf_mode        = val[0];
      CFG_MOVE_NEGATIVE: cf_negative    = val[0];
      CFG_TARGET_PULSES: cf_target      = val[TargetW-1:0];
      CFG_RAMP_STEPS:    cf_ramp_steps  = val[StepW-1:0];
      CFG_STEP_PULSES:   cf_step_pulses = val[PulseW-1:0];
      CFG_BASE_SPEED:    cf_base        = val[BaseW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input bit mode, input bit neg, input int unsigned tgt,
                               input int unsigned steps, input int unsigned pulses,
                               input int unsigned base);
    wait_idle();
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_LO, CfgDataW'($urandom()));
    write_reg(CFG_MOTION_MODE,   pad_cfg(CfgDataW'(mode), 1));
    write_reg(CFG_MOVE_NEGATIVE, pad_cfg(CfgDataW'(neg), 1));
    write_reg(CFG_TARGET_PULSES, pad_cfg(CfgDataW'(tgt), TargetW));
    write_reg(CFG_RAMP_STEPS,    pad_cfg(CfgDataW'(steps), StepW));
    write_reg(CFG_STEP_PULSES,   pad_cfg(CfgDataW'(pulses), PulseW));
    write_reg(CFG_BASE_SPEED,    pad_cfg(CfgDataW'(base), BaseW));
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_HI, CfgDataW'($urandom()));
  endtask

  task automatic random_setting();
    int unsigned steps;
    int unsigned pulses;
    int unsigned tgt;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) steps = 2 * $urandom_range(0, 4);
    else if (r < 90) steps = $urandom_range(0, 8);
    else steps = $urandom_range(9, 15);
    r = $urandom_range(0, 99);
    if (r < 75) pulses = $urandom_range(1, 64);
    else if (r < 92) pulses = $urandom_range(65, 65535);
    else pulses = 0;
    if ($urandom_range(0, 99) < 85) begin
      tgt = ((steps > MaxSteps) ? MaxSteps : steps) * pulses + $urandom_range(0, 4 * pulses + 3);
      if (tgt > 32'h00FF_FFFF) tgt = 32'h00FF_FFFF;
    end else begin
      tgt = $urandom() & 32'h00FF_FFFF;
    end
    apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), tgt, steps, pulses,
                  $urandom_range(0, 127));
  endtask

  task automatic send_start();
    in_item_t it;
    it.start_req = 1'b1;
    it.enc_left  = $urandom();
    it.enc_right = $urandom();
    send_sample(it);
  endtask

  // corrected counts, encoded for the current mode and direction
  task automatic send_counts(input logic [EncW-1:0] c1, input logic [EncW-1:0] c2);
    in_item_t it;
    it.start_req = 1'b0;
    it.enc_left  = encode_count(c1, cf_negative ^ cf_mode);
    it.enc_right = encode_count(c2, cf_negative);
    send_sample(it);
  endtask

  task automatic send_raw(input logic [EncW-1:0] r1, input logic [EncW-1:0] r2);
    in_item_t it;
    it.start_req = 1'b0;
    it.enc_left  = r1;
    it.enc_right = r2;
    send_sample(it);
  endtask

  // start, then rising counts until done or max_samples, with noise and restarts
  task automatic run_move(input int max_samples, input int noise_pct);
    logic [EncW-1:0] pos;
    logic [EncW-1:0] span;
    logic [EncW-1:0] lag;
    in_item_t        it;
    int              n;
    send_start();
    ramp_items++;
    span = cf_target / $urandom_range(6, 30);
    if (span == 0) span = 1;
    pos = '0;
    n = 0;
    while (n < max_samples && pm_moving) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        it.start_req = ($urandom_range(0, 9) == 0);
        it.enc_left  = $urandom();
        it.enc_right = $urandom();
        send_sample(it);
      end else begin
        pos = pos + $urandom_range(0, 2 * span);
        lag = $urandom_range(0, span);
        if ($urandom_range(0, 9) == 0) send_counts(pos - lag, pos);
        else send_counts(pos, pos - lag);
      end
      ramp_items++;
      n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checking
  // ---------------------------------------------------------------------------

  // random stall bursts; a requested hold-off keeps stall high for its countdown
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (holds_served != hold_reqs) begin
      holds_served <= holds_served + 1;
      out_stall_i  <= 1'b1;
      stall_left   <= HoldCycles;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 35);
      stall_left  <= burst_len();
    end
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // compare each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (speed_expect_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_data_o.speed_cmd, 8'h00);
      end else begin
        want_result = speed_expect_q.pop_front();
        if (out_data_o.speed_cmd !== want_result.speed_cmd)
          report_mismatch("speed_cmd", out_data_o.speed_cmd, want_result.speed_cmd);
        if (out_data_o.move_done !== want_result.move_done)
          report_mismatch("move_done", 8'(out_data_o.move_done), 8'(want_result.move_done));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // defaults after reset: idle items, then a zero-target move
  task automatic test_idle_after_reset();
    send_raw('0, '0);
    send_raw('1, '1);
    send_start();
    send_raw(32'h8000_0000, 32'h7FFF_FFFF);
    send_raw('0, '0);
  endtask

  // each mode and direction: a step, a negative count, then the target
  task automatic test_direction_modes();
    for (int m = 0; m < 2; m++) begin
      for (int d = 0; d < 2; d++) begin
        apply_setting(1'(m), 1'(d), 20, 2, 5, 3);
        send_start();
        send_counts(32'd5, 32'd5);
        send_counts(32'h8000_0000, 32'd20);
        send_counts(32'd20, 32'd20);
      end
    end
  endtask

  // register extremes: zero step span, saturated steps, speed clamp, zero target
  task automatic test_register_extremes();
    apply_setting(1'b0, 1'b0, 32'h00FF_FFFF, 15, 0, 127);
    send_start();
    send_counts(32'd0, 32'd0);
    send_counts(32'd1, 32'd0);
    send_counts(32'd2, 32'd1);
    apply_setting(1'b1, 1'b1, 0, 1, 32'h0000_FFFF, 0);
    send_start();
    send_raw('1, '1);
    send_raw('0, '0);
  endtask

  // back-to-back items with the receiver always ready
  task automatic test_full_rate();
    apply_setting(1'b0, 1'b1, 400, 8, 40, 20);
    quiet = 1'b1;
    run_move(60, 0);
    wait_idle();
    quiet = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering samples
  task automatic test_output_backpressure();
    apply_setting(1'b1, 1'b0, 600, 6, 50, 40);
    hold_reqs++;
    run_move(80, 5);
  endtask

  task automatic test_random_moves();
    while (ramp_items < ItemTarget) begin
      if ($urandom_range(0, 5) == 0) random_setting();
      run_move(80, 10);
      // a few items with no armed move
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_raw($urandom(), $urandom());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    cf_mode        = 1'b0;
    cf_negative    = 1'b0;
    cf_target      = '0;
    cf_ramp_steps  = '0;
    cf_step_pulses = 16'd1;
    cf_base        = 7'd1;
    pm_moving      = 1'b0;
    pm_steps_done  = '0;
    pm_accel_mult  = 4'd2;
    pm_decel_mult  = '0;
    pm_decel_point = 0;
    pm_ramp_speed  = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_after_reset();
    test_direction_modes();
    test_register_extremes();
    test_full_rate();
    test_output_backpressure();
    test_random_moves();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/srmp_pkg.sv
design/stepped_ramp_motion_profile_core.sv
design/srmp_checker.sv
verif/tb_stepped_ramp_motion_profile_core.sv
